[design/tspsd_pkg.sv]
// ----------------------------------------------------------------------------
// tspsd_pkg
// Shared constants, payload types and constant tables of the Tukey-windowed
// power spectrogram block.
// ----------------------------------------------------------------------------
package tspsd_pkg;

    localparam int NPERSEG         = 256;
    localparam int BINS_PER_RESULT = 4;
    localparam int SAMPLE_BITS     = 24;

    localparam int NBINS    = NPERSEG / 2 + 1;
    localparam int RING_AW  = $clog2(NPERSEG);
    localparam int CNT_W    = $clog2(NPERSEG + 1);
    localparam int BIN_W    = $clog2(NBINS);
    localparam int SLOT_W   = (BINS_PER_RESULT > 1) ? $clog2(BINS_PER_RESULT) : 1;
    localparam int SEG_W    = 12;
    localparam int SEG_MAX  = 4095;
    localparam int PSD_W    = 48;
    localparam int OVL_W    = 8;
    localparam int SCALE_W  = 32;
    localparam int BASE_W   = 8;
    localparam int WIN_DEN  = 2 * (NPERSEG - 1);

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_IDX_W-1:0] CFG_OVERLAP   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PSD_SCALE = 2'd1;

    localparam logic [OVL_W-1:0]   OVERLAP_RESET   = 8'd128;
    localparam logic [SCALE_W-1:0] PSD_SCALE_RESET = 32'd3460000000;

    localparam longint unsigned Q30         = 64'd1073741824;
    localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

    typedef longint unsigned div_tab_t [7];
    localparam div_tab_t SIN_DIV = '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210};
    localparam div_tab_t COS_DIV = '{64'd2, 64'd12, 64'd30, 64'd56, 64'd90, 64'd132, 64'd182};

    typedef struct packed {
        logic signed [SAMPLE_BITS-1:0] sample;
        logic                          first;
    } in_t;

    typedef struct packed {
        logic [SEG_W-1:0]  segment_index;
        logic [BASE_W-1:0] bin_base;
        logic [PSD_W-1:0]  psd_a;
        logic [PSD_W-1:0]  psd_b;
        logic [PSD_W-1:0]  psd_c;
        logic [PSD_W-1:0]  psd_d;
        logic              last;
    } out_t;

    typedef struct packed {
        logic [SEG_W-1:0]   seg_idx;
        logic [RING_AW-1:0] start_ptr;
    } job_t;

    typedef logic signed [31:0] q30_tab_t [NPERSEG];

    // Taylor series on one quadrant, truncating each term, then quadrant mapping.
    function automatic longint trig_from_angle(input longint unsigned th,
                                               input logic [1:0] quad,
                                               input logic want_sin);
        longint unsigned x2;
        longint unsigned ts;
        longint unsigned tc;
        longint sv;
        longint cv;
        longint c;
        longint s;
        x2 = (th * th) >> 30;
        ts = th;
        tc = Q30;
        sv = longint'(th);
        cv = longint'(Q30);
        for (int k = 0; k < 7; k++) begin
            ts = ((ts * x2) >> 30) / SIN_DIV[k];
            tc = ((tc * x2) >> 30) / COS_DIV[k];
            if ((k % 2) == 0) begin
                sv = sv - longint'(ts);
                cv = cv - longint'(tc);
            end else begin
                sv = sv + longint'(ts);
                cv = cv + longint'(tc);
            end
        end
        if (sv < 0) sv = 0;
        if (sv > longint'(Q30)) sv = longint'(Q30);
        if (cv < 0) cv = 0;
        if (cv > longint'(Q30)) cv = longint'(Q30);
        unique case (quad)
            2'd0: begin c = cv;  s = sv;  end
            2'd1: begin c = -sv; s = cv;  end
            2'd2: begin c = -cv; s = -sv; end
            default: begin c = sv; s = -cv; end
        endcase
        return want_sin ? s : c;
    endfunction

    function automatic q30_tab_t make_trig_tab(input logic want_sin);
        q30_tab_t tab;
        longint unsigned r4;
        longint unsigned rem;
        longint unsigned th;
        for (int i = 0; i < NPERSEG; i++) begin
            r4  = 64'(i) * 64'd4;
            rem = r4 % NPERSEG;
            th  = HALF_PI_Q30 * rem / NPERSEG;
            tab[i] = 32'(trig_from_angle(th, 2'(r4 / NPERSEG), want_sin));
        end
        return tab;
    endfunction

    function automatic q30_tab_t make_win_tab();
        q30_tab_t tab;
        longint unsigned n1;
        longint unsigned num;
        longint unsigned r4;
        longint unsigned rem;
        longint unsigned th;
        longint c;
        n1 = 64'(NPERSEG - 1);
        for (int i = 0; i < NPERSEG; i++) begin
            if (64'(i) * 8 < n1 || 64'(i) * 8 > 7 * n1) begin
                num = (64'(i) * 8 < n1) ? n1 - 64'(i) * 8 : 64'(i) * 8 - 7 * n1;
                r4  = num * 4;
                rem = r4 % WIN_DEN;
                th  = HALF_PI_Q30 * rem / WIN_DEN;
                c   = trig_from_angle(th, 2'(r4 / WIN_DEN), 1'b0);
                tab[i] = 32'((longint'(Q30) + c) >>> 1);
            end else begin
                tab[i] = 32'(Q30);
            end
        end
        return tab;
    endfunction

    localparam q30_tab_t COS_TAB = make_trig_tab(1'b0);
    localparam q30_tab_t SIN_TAB = make_trig_tab(1'b1);
    localparam q30_tab_t WIN_TAB = make_win_tab();

    // Divide by 2^30, rounding half away from zero.
    function automatic logic signed [63:0] round30(input logic signed [63:0] v);
        logic [63:0] mag;
        logic [63:0] r;
        mag = v[63] ? 64'(-v) : 64'(v);
        r   = (mag + 64'd536870912) >> 30;
        return v[63] ? -$signed(r) : $signed(r);
    endfunction

endpackage

[design/tspsd_front.sv]
// ----------------------------------------------------------------------------
// tspsd_front
// Takes samples into the ring, counts segments and hops, and issues a
// transform job for every segment that becomes due.
// ----------------------------------------------------------------------------
module tspsd_front import tspsd_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  in_t                           s_data,
    input  logic [OVL_W-1:0]              overlap,
    output logic                          job_push,
    output job_t                          job,
    input  logic                          q_full,
    input  logic                          win_done,
    input  logic [RING_AW-1:0]            ring_raddr,
    output logic signed [SAMPLE_BITS-1:0] ring_rdata
);

    logic signed [SAMPLE_BITS-1:0] ring [NPERSEG];
    logic signed [SAMPLE_BITS-1:0] rdata_reg;

    logic [RING_AW-1:0] wr_pos_reg, wr_pos_next;
    logic [CNT_W-1:0]   seen_reg, seen_next;
    logic [CNT_W-1:0]   hop_reg, hop_next;
    logic [SEG_W-1:0]   seg_reg, seg_next;
    logic               hold_reg, hold_next;

    logic               accept;
    logic               emit;
    logic [CNT_W-1:0]   seen_base, hop_base, hop_inc, ov_lim, hop_len;
    logic [SEG_W-1:0]   seg_base;

    assign s_ready    = !hold_reg && !q_full;
    assign accept     = s_valid && s_ready;
    assign ring_rdata = rdata_reg;

    always_comb begin
        ov_lim  = (32'(overlap) > 32'(NPERSEG - 1)) ? CNT_W'(NPERSEG - 1) : CNT_W'(overlap);
        hop_len = CNT_W'(NPERSEG) - ov_lim;

        seen_base = s_data.first ? '0 : seen_reg;
        hop_base  = s_data.first ? '0 : hop_reg;
        seg_base  = s_data.first ? '0 : seg_reg;
        hop_inc   = hop_base + 1'b1;

        wr_pos_next = (wr_pos_reg == RING_AW'(NPERSEG - 1)) ? '0 : wr_pos_reg + 1'b1;
        seen_next   = seen_reg;
        hop_next    = hop_reg;
        seg_next    = seg_reg;
        emit        = 1'b0;

        if (seen_base < CNT_W'(NPERSEG)) begin
            seen_next = seen_base + 1'b1;
            emit      = (seen_next == CNT_W'(NPERSEG));
            hop_next  = '0;
        end else begin
            seen_next = seen_base;
            emit      = (hop_inc >= hop_len);
            hop_next  = emit ? '0 : hop_inc;
        end
        seg_next = (emit && seg_base < SEG_W'(SEG_MAX)) ? seg_base + 1'b1 : seg_base;

        job_push      = accept && emit;
        job.seg_idx   = seg_base;
        job.start_ptr = wr_pos_next;

        // The ring must hold still until the job has read its segment out.
        hold_next = hold_reg;
        if (win_done) begin
            hold_next = 1'b0;
        end
        if (job_push) begin
            hold_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            ring[wr_pos_reg] <= s_data.sample;
        end
        rdata_reg <= ring[ring_raddr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_pos_reg <= '0;
            seen_reg   <= '0;
            hop_reg    <= '0;
            seg_reg    <= '0;
            hold_reg   <= 1'b0;
        end else begin
            hold_reg <= hold_next;
            if (accept) begin
                wr_pos_reg <= wr_pos_next;
                seen_reg   <= seen_next;
                hop_reg    <= hop_next;
                seg_reg    <= seg_next;
            end
        end
    end

endmodule

[design/tspsd_queue.sv]
// ----------------------------------------------------------------------------
// tspsd_queue
// Two-entry job queue between the sample front end and the transform engine.
// ----------------------------------------------------------------------------
module tspsd_queue import tspsd_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    input  logic pop,
    output job_t head,
    output logic full,
    output logic empty
);

    job_t       slots [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] count_reg;

    assign head  = slots[rd_ptr_reg];
    assign full  = (count_reg == 2'd2);
    assign empty = (count_reg == 2'd0);

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            slots[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= '0;
        end else begin
            if (push && !full) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop && !empty) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_reg + 2'((push && !full) ? 1 : 0) - 2'((pop && !empty) ? 1 : 0);
        end
    end

endmodule

[design/tspsd_back.sv]
// ----------------------------------------------------------------------------
// tspsd_back
// Transform engine: windows a segment into the work memory, runs the DFT one
// product pair at a time, forms each density with a shift-add multiplier and
// packs the bins into result words.
// ----------------------------------------------------------------------------
module tspsd_back import tspsd_pkg::*; (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  job_t                          head,
    input  logic                          q_empty,
    output logic                          q_pop,
    output logic                          win_done,
    output logic [RING_AW-1:0]            ring_raddr,
    input  logic signed [SAMPLE_BITS-1:0] ring_rdata,
    input  logic [SCALE_W-1:0]            psd_scale,
    output logic                          m_valid,
    input  logic                          m_ready,
    output out_t                          m_data
);

    localparam int WS_W   = SAMPLE_BITS + 1;
    localparam int PROD_W = WS_W + 32;
    localparam int ACC_W  = WS_W + RING_AW + 1;
    localparam int FULL_W = 2 * ACC_W + 1 + SCALE_W;
    localparam int B_W    = (ACC_W > SCALE_W) ? ACC_W : SCALE_W;
    localparam int MCNT_W = $clog2(B_W + 1);
    localparam int SH_D   = 2 * SAMPLE_BITS;

    typedef enum logic [11:0] {
        S_IDLE  = 12'b000000000001,
        S_WADDR = 12'b000000000010,
        S_WMUL  = 12'b000000000100,
        S_WWR   = 12'b000000001000,
        S_DRD   = 12'b000000010000,
        S_DMUL  = 12'b000000100000,
        S_DACC  = 12'b000001000000,
        S_MRE   = 12'b000010000000,
        S_MIM   = 12'b000100000000,
        S_MSC   = 12'b001000000000,
        S_DENS  = 12'b010000000000,
        S_OUT   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;

    logic signed [WS_W-1:0] work [NPERSEG];
    logic signed [WS_W-1:0] work_rd_reg;

    logic [RING_AW-1:0]        i_reg, i_next, idx_reg, idx_next, rptr_reg, rptr_next;
    logic [BIN_W-1:0]          k_reg, k_next, base_reg, base_next;
    logic [SLOT_W-1:0]         slot_reg, slot_next;
    logic [SEG_W-1:0]          seg_reg, seg_next;
    logic signed [ACC_W-1:0]   re_reg, re_next, im_reg, im_next;
    logic signed [PROD_W-1:0]  wprod_reg, wprod_next, pc_reg, pc_next, ps_reg, ps_next;
    logic signed [31:0]        c_reg, s_reg;
    logic [FULL_W-1:0]         a_reg, a_next, acc_reg, acc_next, addend;
    logic [B_W-1:0]            b_reg, b_next;
    logic [MCNT_W-1:0]         cnt_reg, cnt_next;
    logic [PSD_W-1:0]          psd_reg [BINS_PER_RESULT];
    logic                      psd_load, psd_clear;
    logic [PSD_W-1:0]          dens;
    logic                      out_valid_reg, out_valid_next, out_load;
    out_t                      out_reg, out_next;

    logic                      work_we;
    logic signed [WS_W-1:0]    work_wdata;
    logic signed [ACC_W-1:0]   re_acc, im_acc;
    logic [ACC_W-1:0]          re_mag, im_mag;
    logic [RING_AW:0]          idx_sum;
    logic                      doubled, last_bin, last_elem;
    logic [FULL_W:0]           rnd_sum, rnd_shift;

    assign ring_raddr = rptr_reg;
    assign m_valid    = out_valid_reg;
    assign m_data     = out_reg;

    always_comb begin
        state_next     = state_reg;
        i_next         = i_reg;
        idx_next       = idx_reg;
        rptr_next      = rptr_reg;
        k_next         = k_reg;
        base_next      = base_reg;
        slot_next      = slot_reg;
        seg_next       = seg_reg;
        re_next        = re_reg;
        im_next        = im_reg;
        wprod_next     = wprod_reg;
        pc_next        = pc_reg;
        ps_next        = ps_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        out_load       = 1'b0;
        psd_load       = 1'b0;
        psd_clear      = 1'b0;
        q_pop          = 1'b0;
        win_done       = 1'b0;
        work_we        = 1'b0;

        last_elem = (i_reg == RING_AW'(NPERSEG - 1));
        last_bin  = (k_reg == BIN_W'(NBINS - 1));
        doubled   = (k_reg != '0) && !((NPERSEG % 2 == 0) && last_bin);

        work_wdata = WS_W'(round30(64'(wprod_reg)));
        re_acc     = re_reg + ACC_W'(round30(64'(pc_reg)));
        im_acc     = im_reg - ACC_W'(round30(64'(ps_reg)));
        re_mag     = re_acc[ACC_W-1] ? ACC_W'(-re_acc) : ACC_W'(re_acc);
        im_mag     = im_reg[ACC_W-1] ? ACC_W'(-im_reg) : ACC_W'(im_reg);
        idx_sum    = (RING_AW + 1)'(idx_reg) + (RING_AW + 1)'(k_reg);
        addend     = b_reg[0] ? a_reg : '0;

        // Round half up, drop the fraction, saturate to the field.
        rnd_sum   = (FULL_W + 1)'(acc_reg)
                  + (doubled ? ((FULL_W + 1)'(1) << (SH_D - 1)) : ((FULL_W + 1)'(1) << SH_D));
        rnd_shift = doubled ? (rnd_sum >> SH_D) : (rnd_sum >> (SH_D + 1));
        dens      = (rnd_shift > (FULL_W + 1)'({PSD_W{1'b1}})) ? {PSD_W{1'b1}}
                                                              : rnd_shift[PSD_W-1:0];

        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    q_pop      = 1'b1;
                    seg_next   = head.seg_idx;
                    rptr_next  = head.start_ptr;
                    i_next     = '0;
                    k_next     = '0;
                    base_next  = '0;
                    slot_next  = '0;
                    state_next = S_WADDR;
                end
            end
            S_WADDR: begin
                state_next = S_WMUL;
            end
            S_WMUL: begin
                wprod_next = PROD_W'(ring_rdata) * PROD_W'(WIN_TAB[i_reg]);
                state_next = S_WWR;
            end
            S_WWR: begin
                work_we   = 1'b1;
                rptr_next = (rptr_reg == RING_AW'(NPERSEG - 1)) ? '0 : rptr_reg + 1'b1;
                i_next    = i_reg + 1'b1;
                if (last_elem) begin
                    win_done   = 1'b1;
                    i_next     = '0;
                    idx_next   = '0;
                    re_next    = '0;
                    im_next    = '0;
                    state_next = S_DRD;
                end else begin
                    state_next = S_WADDR;
                end
            end
            S_DRD: begin
                state_next = S_DMUL;
            end
            S_DMUL: begin
                pc_next    = PROD_W'(work_rd_reg) * PROD_W'(c_reg);
                ps_next    = PROD_W'(work_rd_reg) * PROD_W'(s_reg);
                state_next = S_DACC;
            end
            S_DACC: begin
                re_next  = re_acc;
                im_next  = im_acc;
                idx_next = (idx_sum >= (RING_AW + 1)'(NPERSEG))
                         ? RING_AW'(idx_sum - (RING_AW + 1)'(NPERSEG)) : RING_AW'(idx_sum);
                i_next   = i_reg + 1'b1;
                if (last_elem) begin
                    a_next     = FULL_W'(re_mag);
                    b_next     = B_W'(re_mag);
                    acc_next   = '0;
                    cnt_next   = MCNT_W'(ACC_W);
                    state_next = S_MRE;
                end else begin
                    state_next = S_DRD;
                end
            end
            S_MRE: begin
                acc_next = acc_reg + addend;
                a_next   = a_reg << 1;
                b_next   = b_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == MCNT_W'(1)) begin
                    a_next     = FULL_W'(im_mag);
                    b_next     = B_W'(im_mag);
                    cnt_next   = MCNT_W'(ACC_W);
                    state_next = S_MIM;
                end
            end
            S_MIM: begin
                acc_next = acc_reg + addend;
                a_next   = a_reg << 1;
                b_next   = b_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == MCNT_W'(1)) begin
                    a_next     = acc_reg + addend;
                    b_next     = B_W'(psd_scale);
                    acc_next   = '0;
                    cnt_next   = MCNT_W'(SCALE_W);
                    state_next = S_MSC;
                end
            end
            S_MSC: begin
                acc_next = acc_reg + addend;
                a_next   = a_reg << 1;
                b_next   = b_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == MCNT_W'(1)) begin
                    state_next = S_DENS;
                end
            end
            S_DENS: begin
                psd_load = 1'b1;
                if (slot_reg == SLOT_W'(BINS_PER_RESULT - 1) || last_bin) begin
                    state_next = S_OUT;
                end else begin
                    slot_next  = slot_reg + 1'b1;
                    k_next     = k_reg + 1'b1;
                    i_next     = '0;
                    idx_next   = '0;
                    re_next    = '0;
                    im_next    = '0;
                    state_next = S_DRD;
                end
            end
            S_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_load                = 1'b1;
                    psd_clear               = 1'b1;
                    out_valid_next          = 1'b1;
                    out_next.segment_index  = seg_reg;
                    out_next.bin_base       = BASE_W'(base_reg);
                    out_next.psd_a          = psd_reg[0];
                    out_next.psd_b          = psd_reg[1];
                    out_next.psd_c          = psd_reg[2];
                    out_next.psd_d          = psd_reg[3];
                    out_next.last           = last_bin;
                    slot_next               = '0;
                    if (last_bin) begin
                        state_next = S_IDLE;
                    end else begin
                        k_next     = k_reg + 1'b1;
                        base_next  = k_reg + 1'b1;
                        i_next     = '0;
                        idx_next   = '0;
                        re_next    = '0;
                        im_next    = '0;
                        state_next = S_DRD;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (work_we) begin
            work[i_reg] <= work_wdata;
        end
        work_rd_reg <= work[i_reg];
        c_reg       <= COS_TAB[idx_reg];
        s_reg       <= SIN_TAB[idx_reg];
        i_reg       <= i_next;
        idx_reg     <= idx_next;
        rptr_reg    <= rptr_next;
        seg_reg     <= seg_next;
        re_reg      <= re_next;
        im_reg      <= im_next;
        wprod_reg   <= wprod_next;
        pc_reg      <= pc_next;
        ps_reg      <= ps_next;
        a_reg       <= a_next;
        b_reg       <= b_next;
        acc_reg     <= acc_next;
        cnt_reg     <= cnt_next;
        if (out_load) begin
            out_reg <= out_next;
        end
        for (int j = 0; j < BINS_PER_RESULT; j++) begin
            if (psd_clear || !aresetn) begin
                psd_reg[j] <= '0;
            end else if (psd_load && slot_reg == SLOT_W'(j)) begin
                psd_reg[j] <= dens;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            k_reg         <= '0;
            base_reg      <= '0;
            slot_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            base_reg      <= base_next;
            slot_reg      <= slot_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

[design/tukey_stft_power_spectrogram_top.sv]
// ----------------------------------------------------------------------------
// tukey_stft_power_spectrogram_top
// One-sided power spectrogram with a Tukey window: sample front end, job
// queue and transform engine, plus the configuration registers.
// ----------------------------------------------------------------------------
// A sample that completes no segment is taken whenever the ring is not held
// and the job queue is not full. A due segment blocks input until its window
// pass is over, which also waits for the rest of any earlier segment's transform.
// Each bin then runs the DFT over the segment, the shift-add products of the
// real part, the imaginary part and the scale, and one load into the result.
// Reset is synchronous and active low; it clears counters, control and the density slots and loads the config defaults.
module tukey_stft_power_spectrogram_top import tspsd_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic [OVL_W-1:0]   overlap_reg;
    logic [SCALE_W-1:0] psd_scale_reg;

    logic                          job_push, q_full, q_empty, q_pop, win_done;
    job_t                          job, head;
    logic [RING_AW-1:0]            ring_raddr;
    logic signed [SAMPLE_BITS-1:0] ring_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overlap_reg   <= OVERLAP_RESET;
            psd_scale_reg <= PSD_SCALE_RESET;
        end else if (cfg_we) begin
            if (cfg_index == CFG_OVERLAP) begin
                overlap_reg <= cfg_wdata[OVL_W-1:0];
            end
            if (cfg_index == CFG_PSD_SCALE) begin
                psd_scale_reg <= cfg_wdata[SCALE_W-1:0];
            end
        end
    end

    tspsd_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .overlap    (overlap_reg),
        .job_push   (job_push),
        .job        (job),
        .q_full     (q_full),
        .win_done   (win_done),
        .ring_raddr (ring_raddr),
        .ring_rdata (ring_rdata)
    );

    tspsd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (job),
        .pop      (q_pop),
        .head     (head),
        .full     (q_full),
        .empty    (q_empty)
    );

    tspsd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .q_empty    (q_empty),
        .q_pop      (q_pop),
        .win_done   (win_done),
        .ring_raddr (ring_raddr),
        .ring_rdata (ring_rdata),
        .psd_scale  (psd_scale_reg),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
